/* src/lud_pkg.sv */
// Shared types, constants and fixed-point helpers for the lens undistort remap unit.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none
package lud_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 512;
    localparam int COLS_W = $clog2(FRAME_WIDTH);
    localparam int ROWS_W = $clog2(FRAME_HEIGHT);
    localparam int ADDR_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

    // Item fields
    localparam int COLUMN_W = 10;
    localparam int LINE_W   = 9;
    localparam int PIX_W    = 8;
    localparam int POS_W    = COLUMN_W;

    // Function codes
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_K1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd7;

    localparam logic [31:0] K1_RESET = 32'hFFB7_7391;
    localparam logic [31:0] K2_RESET = 32'd1240827;
    localparam logic [31:0] P1_RESET = 32'd3248;
    localparam logic [31:0] P2_RESET = 32'd296;
    localparam logic [31:0] FX_RESET = 32'd30058349;
    localparam logic [31:0] FY_RESET = 32'd29969351;
    localparam logic [31:0] CX_RESET = 32'd24065802;
    localparam logic [31:0] CY_RESET = 32'd16277504;

    // Arithmetic widths
    localparam int SAT_W = 44;
    localparam int POSQ_W = 42;
    localparam logic signed [SAT_W-1:0] ONE_Q24 = SAT_W'(1) <<< 24;
    localparam logic signed [POSQ_W-1:0] U_LIMIT = POSQ_W'(FRAME_WIDTH) <<< 16;
    localparam logic signed [POSQ_W-1:0] V_LIMIT = POSQ_W'(FRAME_HEIGHT) <<< 16;

    // Pipeline depths
    localparam int DIV_STAGES = 16;
    localparam int DIV_BITS   = 2;
    localparam int NORM_LAT   = DIV_STAGES + 2;
    localparam int DIST_LAT   = 14;
    localparam int SIDE_LAT   = NORM_LAT + DIST_LAT;

    typedef struct packed {
        logic [31:0] radial_k1;
        logic [31:0] radial_k2;
        logic [31:0] tangential_p1;
        logic [31:0] tangential_p2;
        logic [31:0] focal_x;
        logic [31:0] focal_y;
        logic [31:0] center_x;
        logic [31:0] center_y;
    } lud_cfg_t;

    typedef struct packed {
        logic              func;
        logic              wr_ok;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  pix;
    } lud_side_t;

    typedef struct packed {
        logic              in_frame;
        logic [ADDR_W-1:0] addr;
    } lud_fetch_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_W'(32'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
        else if (v < -(SAT_W'(1) <<< 31)) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Q8.24 product: floor shift by 24, then saturate
    function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 24;
        return sat32(s[SAT_W-1:0]);
    endfunction

endpackage
`default_nettype wire

/* src/lens_undistort_remap_unit.sv */
// Top level of the lens undistort remap unit: registers, frame store, output queue.
// Depends on lud_pkg, lud_norm and lud_distort.
//
//   channel   handshake               payload
//   in        in_valid / in_stall     func, column, line, source_pixel
//   out       out_valid / out_stall   corrected_pixel, inside_frame
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item enters per clock unless in_stall holds it. A fetch item passes through the
// normalizing divider, the distortion datapath, one store read and one queue slot;
// the per-axis divider pipeline is the deepest of these. Store items give no result.
// Reset clears configuration to its defaults and all valid bits; the frame store is
// not cleared. The whole pipeline holds together only when its last stage carries a
// result and the two-entry output queue is full, so an output stall reaches in_stall
// only after the queue fills.
`default_nettype none
module lens_undistort_remap_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           func,
    input  wire logic [lud_pkg::COLUMN_W-1:0]   column,
    input  wire logic [lud_pkg::LINE_W-1:0]     line,
    input  wire logic [lud_pkg::PIX_W-1:0]      source_pixel,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lud_pkg::PIX_W-1:0]           corrected_pixel,
    output logic                                inside_frame,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lud_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    localparam int AW = lud_pkg::ADDR_W;
    localparam int LAST = lud_pkg::SIDE_LAT - 1;

    lud_pkg::lud_cfg_t cfg_reg;

    lud_pkg::lud_side_t side_reg [0:LAST];
    logic               side_valid_reg [0:LAST];
    lud_pkg::lud_side_t side_in;

    logic signed [31:0] norm_x, norm_y;
    lud_pkg::lud_fetch_t fetch;

    logic [lud_pkg::PIX_W-1:0] store [0:(lud_pkg::FRAME_WIDTH * lud_pkg::FRAME_HEIGHT) - 1];
    logic [lud_pkg::PIX_W-1:0] mem_q_reg;
    logic                      m_valid_reg;
    logic                      m_inside_reg;

    logic [lud_pkg::PIX_W-1:0] q_pix_reg [0:1];
    logic                      q_in_reg  [0:1];
    logic [1:0]                q_count_reg;
    logic                      q_rd_reg;
    logic                      q_wr_reg;

    logic adv;
    logic push;
    logic pop;

    // Hold everything only when the finished result has nowhere to go
    assign adv      = !(m_valid_reg && (q_count_reg == 2'd2));
    assign in_stall = !adv;
    assign push     = adv && m_valid_reg;
    assign pop      = out_valid && !out_stall;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radial_k1     <= lud_pkg::K1_RESET;
            cfg_reg.radial_k2     <= lud_pkg::K2_RESET;
            cfg_reg.tangential_p1 <= lud_pkg::P1_RESET;
            cfg_reg.tangential_p2 <= lud_pkg::P2_RESET;
            cfg_reg.focal_x       <= lud_pkg::FX_RESET;
            cfg_reg.focal_y       <= lud_pkg::FY_RESET;
            cfg_reg.center_x      <= lud_pkg::CX_RESET;
            cfg_reg.center_y      <= lud_pkg::CY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lud_pkg::REG_K1: cfg_reg.radial_k1     <= cfg_data;
                lud_pkg::REG_K2: cfg_reg.radial_k2     <= cfg_data;
                lud_pkg::REG_P1: cfg_reg.tangential_p1 <= cfg_data;
                lud_pkg::REG_P2: cfg_reg.tangential_p2 <= cfg_data;
                lud_pkg::REG_FX: cfg_reg.focal_x       <= cfg_data;
                lud_pkg::REG_FY: cfg_reg.focal_y       <= cfg_data;
                lud_pkg::REG_CX: cfg_reg.center_x      <= cfg_data;
                lud_pkg::REG_CY: cfg_reg.center_y      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sideband for each item: store address resolved at entry, writes outside the frame dropped
    always_comb
    begin
        side_in.func  = func;
        side_in.wr_ok = (32'(column) < 32'(lud_pkg::FRAME_WIDTH))
                     && (32'(line) < 32'(lud_pkg::FRAME_HEIGHT));
        side_in.waddr = AW'(AW'(line) * lud_pkg::FRAME_WIDTH) + AW'(column);
        side_in.pix   = source_pixel;
    end

    // Valid bits travel with the sideband; the datapath registers carry no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LAST; s++)
                side_valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            side_valid_reg[0] <= in_valid;
            for (int s = 1; s <= LAST; s++)
                side_valid_reg[s] <= side_valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s <= LAST; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    lud_norm u_norm_x (
        .clk    (clk),
        .adv    (adv),
        .pos    (column),
        .center (cfg_reg.center_x),
        .focal  (cfg_reg.focal_x),
        .norm   (norm_x)
    );

    lud_norm u_norm_y (
        .clk    (clk),
        .adv    (adv),
        .pos    (lud_pkg::POS_W'(line)),
        .center (cfg_reg.center_y),
        .focal  (cfg_reg.focal_y),
        .norm   (norm_y)
    );

    lud_distort u_distort (
        .clk   (clk),
        .adv   (adv),
        .cfg   (cfg_reg),
        .x     (norm_x),
        .y     (norm_y),
        .fetch (fetch)
    );

    // Frame store: writes and reads meet here in item order
    always_ff @(posedge clk)
    begin
        if (adv && side_valid_reg[LAST] && (side_reg[LAST].func == lud_pkg::FUNC_STORE)
            && side_reg[LAST].wr_ok)
            store[side_reg[LAST].waddr] <= side_reg[LAST].pix;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem_q_reg    <= store[fetch.addr];
            m_inside_reg <= fetch.in_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (adv)
            m_valid_reg <= side_valid_reg[LAST] && (side_reg[LAST].func == lud_pkg::FUNC_FETCH);
    end

    // Two-entry output queue parts the pipeline from the consumer
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_pix_reg[q_wr_reg] <= m_inside_reg ? mem_q_reg : '0;
            q_in_reg[q_wr_reg]  <= m_inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= 2'd0;
            q_rd_reg    <= 1'b0;
            q_wr_reg    <= 1'b0;
        end
        else
        begin
            if (push)
                q_wr_reg <= !q_wr_reg;
            if (pop)
                q_rd_reg <= !q_rd_reg;
            if (push && !pop)
                q_count_reg <= q_count_reg + 2'd1;
            else if (pop && !push)
                q_count_reg <= q_count_reg - 2'd1;
        end
    end

    assign out_valid       = (q_count_reg != 2'd0);
    assign corrected_pixel = q_pix_reg[q_rd_reg];
    assign inside_frame    = q_in_reg[q_rd_reg];

endmodule
`default_nettype wire

/* src/lud_norm.sv */
// Normalizer for one axis: ((pos << 16) - center) * 2^24 / focal, saturated Q8.24.
// Pipelined restoring divider, two quotient bits per stage; uses lud_pkg.
`default_nettype none
module lud_norm (
    input  wire logic                      clk,
    input  wire logic                      adv,
    input  wire logic [lud_pkg::POS_W-1:0] pos,
    input  wire logic [31:0]               center,
    input  wire logic [31:0]               focal,
    output logic signed [31:0]             norm
);

    logic signed [32:0] diff;
    logic [31:0] mag;
    logic [31:0] dv;
    logic        ovf;

    logic [31:0] rem_reg [0:lud_pkg::DIV_STAGES];
    logic [31:0] quo_reg [0:lud_pkg::DIV_STAGES];
    logic [7:0]  lo_reg  [0:lud_pkg::DIV_STAGES];
    logic        neg_reg [0:lud_pkg::DIV_STAGES];
    logic        ovf_reg [0:lud_pkg::DIV_STAGES];

    logic [31:0] rem_next [1:lud_pkg::DIV_STAGES];
    logic [31:0] quo_next [1:lud_pkg::DIV_STAGES];
    logic [7:0]  lo_next  [1:lud_pkg::DIV_STAGES];

    logic signed [31:0] norm_reg;
    logic [31:0] qq;

    assign dv   = (focal == 32'd0) ? 32'd1 : focal;
    assign diff = $signed({7'd0, pos, 16'd0}) - $signed({1'b0, center});
    assign mag  = diff[32] ? 32'(-diff) : diff[31:0];
    // quotient would reach 2^32: magnitude at least divisor << 8
    assign ovf  = {8'd0, mag} >= {dv, 8'd0};

    always_comb
    begin
        logic [31:0] r;
        logic [31:0] q;
        logic [7:0]  l;
        logic [32:0] t;
        for (int s = 1; s <= lud_pkg::DIV_STAGES; s++)
        begin
            r = rem_reg[s-1];
            q = quo_reg[s-1];
            l = lo_reg[s-1];
            for (int b = 0; b < lud_pkg::DIV_BITS; b++)
            begin
                t = {r, l[7]};
                l = {l[6:0], 1'b0};
                if (t >= {1'b0, dv})
                begin
                    r = 32'(t - {1'b0, dv});
                    q = {q[30:0], 1'b1};
                end
                else
                begin
                    r = t[31:0];
                    q = {q[30:0], 1'b0};
                end
            end
            rem_next[s] = r;
            quo_next[s] = q;
            lo_next[s]  = l;
        end
    end

    // clamp magnitude to 2^31
    assign qq = (ovf_reg[lud_pkg::DIV_STAGES] || (quo_reg[lud_pkg::DIV_STAGES] > 32'h8000_0000))
              ? 32'h8000_0000 : quo_reg[lud_pkg::DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= {8'd0, mag[31:8]};
            quo_reg[0] <= '0;
            lo_reg[0]  <= mag[7:0];
            neg_reg[0] <= diff[32];
            ovf_reg[0] <= ovf;
            for (int s = 1; s <= lud_pkg::DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                lo_reg[s]  <= lo_next[s];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
            if (neg_reg[lud_pkg::DIV_STAGES])
                norm_reg <= $signed(~qq + 32'd1);
            else if (qq[31])
                norm_reg <= 32'sh7FFF_FFFF;
            else
                norm_reg <= $signed(qq);
        end
    end

    assign norm = norm_reg;

endmodule
`default_nettype wire

/* src/lud_distort.sv */
// Radial and tangential distortion of a normalized point, mapped back to a store address.
// Fourteen register stages, at most one multiplier deep each; uses lud_pkg.
`default_nettype none
module lud_distort (
    input  wire logic               clk,
    input  wire logic               adv,
    input  wire lud_pkg::lud_cfg_t  cfg,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    output lud_pkg::lud_fetch_t     fetch
);

    localparam int SW = lud_pkg::SAT_W;
    localparam int PW = lud_pkg::POSQ_W;

    logic signed [31:0] k1, k2, p1, p2;
    assign k1 = $signed(cfg.radial_k1);
    assign k2 = $signed(cfg.radial_k2);
    assign p1 = $signed(cfg.tangential_p1);
    assign p2 = $signed(cfg.tangential_p2);

    // D1
    logic signed [63:0] pxx_reg, pyy_reg, pxy_reg;
    logic signed [31:0] x1_reg, y1_reg;
    // D2
    logic signed [31:0] x2_reg, y2_reg, xy2_reg, x_d2_reg, y_d2_reg;
    // D3
    logic signed [31:0] r2_reg, x2_d3_reg, y2_d3_reg, xy_d3_reg, x_d3_reg, y_d3_reg;
    // D4
    logic signed [63:0] pr4_reg, pk1_reg, pp1xy_reg, pp2xy_reg;
    logic signed [31:0] ax_reg, ay_reg, x_d4_reg, y_d4_reg;
    // D5
    logic signed [31:0] r4_reg, k1r2_reg, p1xy_reg, p2xy_reg, x_d5_reg, y_d5_reg;
    logic signed [63:0] pp2ax_reg, pp1ay_reg;
    // D6
    logic signed [63:0] pk2r4_reg;
    logic signed [31:0] p2ax_reg, p1ay_reg, k1r2_d6_reg, p1xy_d6_reg, p2xy_d6_reg;
    logic signed [31:0] x_d6_reg, y_d6_reg;
    // D7
    logic signed [31:0] k2r4_reg, p2ax_d7_reg, p1ay_d7_reg, k1r2_d7_reg, p1xy_d7_reg;
    logic signed [31:0] p2xy_d7_reg, x_d7_reg, y_d7_reg;
    // D8
    logic signed [31:0] rad_reg, p2ax_d8_reg, p1ay_d8_reg, p1xy_d8_reg, p2xy_d8_reg;
    logic signed [31:0] x_d8_reg, y_d8_reg;
    // D9
    logic signed [63:0] pxr_reg, pyr_reg;
    logic signed [31:0] p2ax_d9_reg, p1ay_d9_reg, p1xy_d9_reg, p2xy_d9_reg;
    // D10
    logic signed [31:0] xr_reg, yr_reg, p2ax_d10_reg, p1ay_d10_reg, p1xy_d10_reg, p2xy_d10_reg;
    // D11
    logic signed [31:0] xd_reg, yd_reg;
    // D12
    logic signed [64:0] pu_reg, pv_reg;
    // D13
    logic signed [PW-1:0] ud_reg, vd_reg;
    // D14
    lud_pkg::lud_fetch_t fetch_reg;

    logic signed [64:0] pu_sh, pv_sh;
    logic [lud_pkg::COLS_W-1:0] sc;
    logic [lud_pkg::ROWS_W-1:0] sr;

    assign pu_sh = pu_reg >>> 24;
    assign pv_sh = pv_reg >>> 24;
    assign sc = ud_reg[16 +: lud_pkg::COLS_W];
    assign sr = vd_reg[16 +: lud_pkg::ROWS_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxx_reg <= x * x;
            pyy_reg <= y * y;
            pxy_reg <= x * y;
            x1_reg  <= x;
            y1_reg  <= y;

            x2_reg   <= lud_pkg::qmul(pxx_reg);
            y2_reg   <= lud_pkg::qmul(pyy_reg);
            xy2_reg  <= lud_pkg::qmul(pxy_reg);
            x_d2_reg <= x1_reg;
            y_d2_reg <= y1_reg;

            r2_reg    <= lud_pkg::sat32(SW'(x2_reg) + SW'(y2_reg));
            x2_d3_reg <= x2_reg;
            y2_d3_reg <= y2_reg;
            xy_d3_reg <= xy2_reg;
            x_d3_reg  <= x_d2_reg;
            y_d3_reg  <= y_d2_reg;

            pr4_reg   <= r2_reg * r2_reg;
            pk1_reg   <= k1 * r2_reg;
            pp1xy_reg <= p1 * xy_d3_reg;
            pp2xy_reg <= p2 * xy_d3_reg;
            ax_reg    <= lud_pkg::sat32(SW'(r2_reg) + (SW'(x2_d3_reg) <<< 1));
            ay_reg    <= lud_pkg::sat32(SW'(r2_reg) + (SW'(y2_d3_reg) <<< 1));
            x_d4_reg  <= x_d3_reg;
            y_d4_reg  <= y_d3_reg;

            r4_reg    <= lud_pkg::qmul(pr4_reg);
            k1r2_reg  <= lud_pkg::qmul(pk1_reg);
            p1xy_reg  <= lud_pkg::qmul(pp1xy_reg);
            p2xy_reg  <= lud_pkg::qmul(pp2xy_reg);
            pp2ax_reg <= p2 * ax_reg;
            pp1ay_reg <= p1 * ay_reg;
            x_d5_reg  <= x_d4_reg;
            y_d5_reg  <= y_d4_reg;

            pk2r4_reg   <= k2 * r4_reg;
            p2ax_reg    <= lud_pkg::qmul(pp2ax_reg);
            p1ay_reg    <= lud_pkg::qmul(pp1ay_reg);
            k1r2_d6_reg <= k1r2_reg;
            p1xy_d6_reg <= p1xy_reg;
            p2xy_d6_reg <= p2xy_reg;
            x_d6_reg    <= x_d5_reg;
            y_d6_reg    <= y_d5_reg;

            k2r4_reg    <= lud_pkg::qmul(pk2r4_reg);
            p2ax_d7_reg <= p2ax_reg;
            p1ay_d7_reg <= p1ay_reg;
            k1r2_d7_reg <= k1r2_d6_reg;
            p1xy_d7_reg <= p1xy_d6_reg;
            p2xy_d7_reg <= p2xy_d6_reg;
            x_d7_reg    <= x_d6_reg;
            y_d7_reg    <= y_d6_reg;

            rad_reg     <= lud_pkg::sat32(lud_pkg::ONE_Q24 + SW'(k1r2_d7_reg) + SW'(k2r4_reg));
            p2ax_d8_reg <= p2ax_d7_reg;
            p1ay_d8_reg <= p1ay_d7_reg;
            p1xy_d8_reg <= p1xy_d7_reg;
            p2xy_d8_reg <= p2xy_d7_reg;
            x_d8_reg    <= x_d7_reg;
            y_d8_reg    <= y_d7_reg;

            pxr_reg     <= x_d8_reg * rad_reg;
            pyr_reg     <= y_d8_reg * rad_reg;
            p2ax_d9_reg <= p2ax_d8_reg;
            p1ay_d9_reg <= p1ay_d8_reg;
            p1xy_d9_reg <= p1xy_d8_reg;
            p2xy_d9_reg <= p2xy_d8_reg;

            xr_reg       <= lud_pkg::qmul(pxr_reg);
            yr_reg       <= lud_pkg::qmul(pyr_reg);
            p2ax_d10_reg <= p2ax_d9_reg;
            p1ay_d10_reg <= p1ay_d9_reg;
            p1xy_d10_reg <= p1xy_d9_reg;
            p2xy_d10_reg <= p2xy_d9_reg;

            xd_reg <= lud_pkg::sat32(SW'(xr_reg) + (SW'(p1xy_d10_reg) <<< 1) + SW'(p2ax_d10_reg));
            yd_reg <= lud_pkg::sat32(SW'(yr_reg) + (SW'(p2xy_d10_reg) <<< 1) + SW'(p1ay_d10_reg));

            pu_reg <= $signed({1'b0, cfg.focal_x}) * xd_reg;
            pv_reg <= $signed({1'b0, cfg.focal_y}) * yd_reg;

            ud_reg <= pu_sh[PW-1:0] + $signed({10'd0, cfg.center_x});
            vd_reg <= pv_sh[PW-1:0] + $signed({10'd0, cfg.center_y});

            fetch_reg.in_frame <= !ud_reg[PW-1] && !vd_reg[PW-1]
                               && (ud_reg < lud_pkg::U_LIMIT) && (vd_reg < lud_pkg::V_LIMIT);
            fetch_reg.addr     <= lud_pkg::ADDR_W'(lud_pkg::ADDR_W'(sr) * lud_pkg::FRAME_WIDTH)
                               + lud_pkg::ADDR_W'(sc);
        end
    end

    assign fetch = fetch_reg;

endmodule
`default_nettype wire
